@@ design/lowprec_float_exact_product_defines.svh @@
// assertion macros for the exact product block
`ifndef LOWPREC_FLOAT_EXACT_PRODUCT_DEFINES_SVH
`define LOWPREC_FLOAT_EXACT_PRODUCT_DEFINES_SVH

`define LFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lfp_pkg.sv @@
`default_nettype none
package lfp_pkg;
    localparam logic [1:0] FMT_BF16 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_E4M3 = 2'd2;
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_ZERO_EXP = 2'd1;
    localparam int SIG_W = 11;
    localparam int EXP_W = 11;
    localparam int PROD_W = 25;
    localparam int DATA_W = 32;
    localparam int OUT_W = 40;

    typedef struct packed {
        logic             sign;
        logic [EXP_W-1:0] exponent;
        logic [SIG_W-1:0] sig;
    } unpacked_t;
endpackage
`default_nettype wire

@@ design/lowprec_float_exact_product.sv @@
`default_nettype none
`include "lowprec_float_exact_product_defines.svh"
// exact product of two bfloat16, float16 or fp8 e4m3 operands; one item per cycle;
// from acceptance an item passes an input register, then one 11x11 multiply
// and exponent add into the output register; a stalled result still lets the input
// register load once, so full rate holds whenever the output side takes items
module lowprec_float_exact_product (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // operand_a, operand_b
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // product_sign, product_exponent, product_significand
);
    logic [1:0]  fmt_reg;
    logic [10:0] zexp_reg;
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        out_load, in_load;
    lfp_pkg::unpacked_t ua, ub;
    logic [21:0] prod;
    logic [24:0] sig_next;
    logic [10:0] exp_sum, exp_next;
    logic [10:0] bias2;

    lfp_unpack u_a (.operand(in_data_reg[15:0]),  .fmt(fmt_reg), .fields(ua));
    lfp_unpack u_b (.operand(in_data_reg[31:16]), .fmt(fmt_reg), .fields(ub));

    assign out_load = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        prod = ua.sig * ub.sig;
        if (fmt_reg == lfp_pkg::FMT_BF16)
        begin
            sig_next = {prod[15:0], 9'd0};
            bias2 = 11'd254;
        end
        else if (fmt_reg == lfp_pkg::FMT_FP16)
        begin
            sig_next = {prod[21:0], 3'd0};
            bias2 = 11'd30;
        end
        else
        begin
            sig_next = {prod[7:0], 17'd0};
            bias2 = 11'd14;
        end
        exp_sum = ua.exponent + ub.exponent - bias2;
        exp_next = (sig_next == 25'd0) ? zexp_reg : exp_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= lfp_pkg::FMT_BF16;
            zexp_reg <= '0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == lfp_pkg::REG_FORMAT[0:0])
                fmt_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == lfp_pkg::REG_ZERO_EXP[0:0])
                zexp_reg <= cfg_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_data_reg <= s_axis_tdata;
        if (out_load)
            out_data_reg <= {3'd0, sig_next, exp_next, ua.sign ^ ub.sign};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    `LFP_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `LFP_ASSERT_IMPL(a_zero, clk, rst_n, out_load && sig_next == 25'd0,
        exp_next == zexp_reg, "zero product exponent wrong")
    `LFP_ASSERT_NEXT(a_move, clk, rst_n, out_load, m_axis_tvalid,
        "loaded item not shown")
endmodule
`default_nettype wire

@@ design/lfp_unpack.sv @@
`default_nettype none
module lfp_unpack (
    input  wire logic [15:0]        operand,
    input  wire logic [1:0]         fmt,
    output lfp_pkg::unpacked_t      fields
);
    logic [7:0] e;
    logic [9:0] m;
    logic       hid;

    always_comb
    begin
        fields = '0;
        if (fmt == lfp_pkg::FMT_BF16)
        begin
            fields.sign = operand[15];
            e = operand[14:7];
            m = {3'd0, operand[6:0]};
            hid = (e != 8'd0);
            fields.sig = {3'd0, hid, m[6:0]};
        end
        else if (fmt == lfp_pkg::FMT_FP16)
        begin
            fields.sign = operand[15];
            e = {3'd0, operand[14:10]};
            m = operand[9:0];
            hid = (e != 8'd0);
            fields.sig = {hid, m};
        end
        else
        begin
            fields.sign = operand[7];
            e = {4'd0, operand[6:3]};
            m = {7'd0, operand[2:0]};
            hid = (e != 8'd0);
            fields.sig = {7'd0, hid, m[2:0]};
        end
        fields.exponent = hid ? {3'd0, e} : 11'd1;
    end
endmodule
`default_nettype wire
